FILE: rtl/cfd_pkg.sv
// Shared types, constants and the CRC-8 step for the command frame deframer.
`default_nettype none
package cfd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] IgnoreByte    = 8'hFF;
  localparam logic [7:0] CrcPoly       = 8'h07;
  localparam logic [7:0] HeaderFirstRst  = 8'h12;
  localparam logic [7:0] HeaderSecondRst = 8'h34;
  localparam logic [7:0] TypeRoute     = 8'h01;
  localparam logic [7:0] TypeStop      = 8'h04;
  localparam logic [7:0] LenRoute      = 8'd8;
  localparam logic [7:0] LenShort      = 8'd4;

  localparam logic CfgHeaderFirst  = 1'b0;
  localparam logic CfgHeaderSecond = 1'b1;

  typedef enum logic [1:0] {
    KindRoute   = 2'd0,
    KindVersion = 2'd1,
    KindPoll    = 2'd2,
    KindStop    = 2'd3
  } frame_kind_e;

  typedef enum logic [6:0] {
    PhHunt1  = 7'b0000001,
    PhHunt2  = 7'b0000010,
    PhType   = 7'b0000100,
    PhLenOk  = 7'b0001000,
    PhLenBad = 7'b0010000,
    PhData   = 7'b0100000,
    PhCrc    = 7'b1000000
  } phase_e;

  typedef struct packed {
    frame_kind_e kind;
    logic        crc_match;
    logic [31:0] word_first;
    logic [31:0] word_second;
  } frame_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cfd_parser.sv
// Front end: byte filter, header hunt, frame classification and CRC-8 check.
`default_nettype none
module cfd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          rx_valid_i,
  output logic               rx_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output cfd_pkg::frame_t    push_frame_o
);
  import cfd_pkg::*;

  logic [7:0]  hdr_first_q, hdr_second_q;
  phase_e      phase_q, phase_d;
  frame_kind_e kind_q, kind_d;
  logic [3:0]  left_q, left_d;
  logic [7:0]  crc_q, crc_d;
  logic [63:0] shift_q, shift_d;
  logic        act;
  logic [3:0]  left_dec;
  logic [7:0]  exp_len;

  // only a CRC byte needs queue space
  assign rx_ready_o = !q_full_i || (phase_q != PhCrc);
  assign act        = rx_valid_i && rx_ready_o && (rx_byte_i != IgnoreByte);
  assign left_dec   = left_q - 4'd1;
  assign exp_len    = (kind_q == KindRoute) ? LenRoute : LenShort;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    left_d  = left_q;
    crc_d   = crc_q;
    shift_d = shift_q;
    push_o  = 1'b0;
    if (act) begin
      case (phase_q)
        PhHunt2: begin
          phase_d = (rx_byte_i != 8'd0 && rx_byte_i == hdr_second_q) ? PhType : PhHunt1;
        end
        PhType: begin
          if (rx_byte_i == 8'd0) begin
            phase_d = PhHunt1;
          end else if (rx_byte_i >= TypeRoute && rx_byte_i <= TypeStop) begin
            kind_d  = frame_kind_e'(rx_byte_i[1:0] - 2'd1);
            phase_d = PhLenOk;
          end else begin
            phase_d = PhLenBad;
          end
        end
        PhLenOk: begin
          if (rx_byte_i == exp_len) begin
            left_d  = exp_len[3:0];
            crc_d   = 8'd0;
            shift_d = 64'd0;
            phase_d = PhData;
          end else begin
            phase_d = PhHunt1;
          end
        end
        PhLenBad: phase_d = PhHunt1;
        PhData: begin
          crc_d   = crc8_step(crc_q, rx_byte_i);
          shift_d = {rx_byte_i, shift_q[63:8]};
          left_d  = left_dec;
          if (left_dec == 4'd0) begin
            phase_d = PhCrc;
          end
        end
        PhCrc: begin
          push_o  = 1'b1;
          phase_d = PhHunt1;
        end
        default: begin
          phase_d = (rx_byte_i != 8'd0 && rx_byte_i == hdr_first_q) ? PhHunt2 : PhHunt1;
        end
      endcase
    end
  end

  always_comb begin
    push_frame_o.kind      = kind_q;
    push_frame_o.crc_match = (rx_byte_i == crc_q);
    if (kind_q == KindRoute) begin
      push_frame_o.word_first  = shift_q[31:0];
      push_frame_o.word_second = shift_q[63:32];
    end else begin
      push_frame_o.word_first  = 32'd0;
      push_frame_o.word_second = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
      phase_q      <= PhHunt1;
      kind_q       <= KindRoute;
      left_q       <= 4'd0;
      crc_q        <= 8'd0;
      shift_q      <= 64'd0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHeaderFirst) begin
          hdr_first_q <= cfg_data_i;
        end else begin
          hdr_second_q <= cfg_data_i;
        end
      end
      phase_q <= phase_d;
      kind_q  <= kind_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      shift_q <= shift_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cfd_queue.sv
// Back end: short result queue whose head drives the result channel.
`default_nettype none
module cfd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cfd_pkg::frame_t push_frame_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cfd_pkg::frame_t    out_frame_o
);
  import cfd_pkg::*;

  frame_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  count_q, count_d;
  logic                  pop;

  assign full_o      = (count_q == QueueCntW'(QueueDepth));
  assign out_valid_o = (count_q != '0);
  assign out_frame_o = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crc8_command_frame_deframer.sv
// Top level of the CRC-8 command frame deframer.
//
//   channel  dir  handshake                    payload
//   rx       in   rx_valid_i / rx_ready_o      rx_byte_i
//   frame    out  frame_valid_o / frame_ready_i frame_kind_o, crc_match_o,
//                                              route_word_first_o, route_word_second_o
//   cfg      in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// One byte per cycle while rx is not stalled; the parser state machine and CRC-8 step are combinational.
// A result is in the two-entry queue the cycle after its CRC byte is taken.
// rx stalls only on a CRC byte while the queue is full; other bytes flow on.
// Reset sets the headers to 0x12 / 0x34 and starts the hunt for the first header.
`default_nettype none
module crc8_command_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             frame_valid_o,
  input  wire logic        frame_ready_i,
  output logic [1:0]       frame_kind_o,
  output logic             crc_match_o,
  output logic [31:0]      route_word_first_o,
  output logic [31:0]      route_word_second_o
);
  import cfd_pkg::*;

  logic   push, q_full;
  frame_t push_frame, out_frame;

  cfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  cfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .full_o       (q_full),
    .out_valid_o  (frame_valid_o),
    .out_ready_i  (frame_ready_i),
    .out_frame_o  (out_frame)
  );

  assign frame_kind_o        = out_frame.kind;
  assign crc_match_o         = out_frame.crc_match;
  assign route_word_first_o  = out_frame.word_first;
  assign route_word_second_o = out_frame.word_second;

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("result pushed into full queue");

  a_ignore_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_valid_i && rx_ready_o && rx_byte_i == IgnoreByte) |-> !push)
    else $error("ignored byte produced a result");

  a_words_zero_non_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && frame_kind_o != KindRoute) |->
      (route_word_first_o == 32'd0 && route_word_second_o == 32'd0))
    else $error("route words set on non-route frame");

endmodule
`default_nettype wire
